// ===== sv/ioc_pkg.sv =====
`timescale 1ns / 1ps

package ioc_pkg;

  localparam int IOC_SAMPLE_COUNT = 200;
  localparam int IOC_DATA_W       = 16;
  localparam int IOC_SUM_W        = 24;
  localparam int IOC_COUNT_W      = 8;
  localparam int IOC_LANES        = 6;

  // lane order: accel x, y, z, then gyro x, y, z
  localparam int IOC_LANE_ACC_Z   = 2;
  localparam int IOC_LANE_GYRO_X  = 3;

  typedef logic signed [IOC_DATA_W-1:0] ioc_word_t;
  typedef logic signed [IOC_SUM_W-1:0]  ioc_sum_t;
  typedef logic [IOC_COUNT_W-1:0]       ioc_count_t;

  typedef struct packed {
    logic sum_clr;
    logic sum_add;
  } ioc_sum_cmd_t;

  typedef struct packed {
    logic ofs_clr;
    logic ofs_load;
  } ioc_ofs_cmd_t;

  typedef struct packed {
    logic gyro_cal_done;
    logic acc_cal_done;
    logic gyro_offset_ready;
    logic acc_offset_ready;
  } ioc_flags_t;

endpackage

// ===== sv/ioc_ifs.sv =====
`timescale 1ns / 1ps

interface ioc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x_raw;
  logic signed [15:0] acc_y_raw;
  logic signed [15:0] acc_z_raw;
  logic signed [15:0] gyro_x_raw;
  logic signed [15:0] gyro_y_raw;
  logic signed [15:0] gyro_z_raw;
  logic               request_gyro_cal;
  logic               request_acc_cal;

  modport source (
    output valid, acc_x_raw, acc_y_raw, acc_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output request_gyro_cal, request_acc_cal,
    input  ready
  );
  modport sink (
    input  valid, acc_x_raw, acc_y_raw, acc_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  request_gyro_cal, request_acc_cal,
    output ready
  );
endinterface

interface ioc_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic               gyro_cal_done;
  logic               acc_cal_done;
  logic               gyro_offset_ready;
  logic               acc_offset_ready;

  modport source (
    output valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    output gyro_cal_done, acc_cal_done, gyro_offset_ready, acc_offset_ready,
    input  ready
  );
  modport sink (
    input  valid, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    input  gyro_cal_done, acc_cal_done, gyro_offset_ready, acc_offset_ready,
    output ready
  );
endinterface

// ===== sv/ioc_lane.sv =====
`timescale 1ns / 1ps

module ioc_lane
  import ioc_pkg::*;
#(
  parameter int SAMPLE_COUNT = IOC_SAMPLE_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_fire,
  input  ioc_word_t    raw,
  input  ioc_sum_cmd_t sum_cmd,
  input  logic         s1_fire,
  input  ioc_ofs_cmd_t ofs_cmd,
  output ioc_word_t    value
);

  // reciprocal of the sample count, exact for magnitudes below 2^23
  localparam int          MAG_W      = IOC_SUM_W - 1;
  localparam int          DIV_SHIFT  = MAG_W + IOC_COUNT_W;
  localparam int          MULT_W     = DIV_SHIFT;
  localparam logic [63:0] ONE_SHIFT  = 64'd1 << DIV_SHIFT;
  localparam logic [63:0] DIV_MULT_W = (ONE_SHIFT + 64'(SAMPLE_COUNT) - 64'd1)
                                       / 64'(SAMPLE_COUNT);
  localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_W[MULT_W-1:0];
  localparam int          Q_W        = IOC_DATA_W + 1;

  ioc_word_t                 raw_s1;
  ioc_word_t                 offset;
  ioc_sum_t                  sum;
  logic                      sum_neg;
  logic [IOC_SUM_W-1:0]      sum_abs;
  logic [MAG_W+MULT_W-1:0]   prod;
  logic [Q_W-1:0]            q_mag;
  logic [Q_W-1:0]            q_signed;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      raw_s1 <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (in_fire) begin
      if (sum_cmd.sum_clr) begin
        sum <= '0;
      end else if (sum_cmd.sum_add) begin
        sum <= sum + IOC_SUM_W'(raw);
      end
    end
  end

  // truncating divide of the running sum, sign and magnitude
  always_comb begin
    sum_neg  = sum[IOC_SUM_W-1];
    sum_abs  = sum_neg ? IOC_SUM_W'(-sum) : IOC_SUM_W'(sum);
    prod     = sum_abs[MAG_W-1:0] * DIV_MULT;
    q_mag    = prod[DIV_SHIFT +: Q_W];
    q_signed = sum_neg ? Q_W'(-q_mag) : q_mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (s1_fire) begin
      if (ofs_cmd.ofs_clr) begin
        offset <= '0;
      end else if (ofs_cmd.ofs_load) begin
        offset <= q_signed[IOC_DATA_W-1:0];
      end
    end
  end

  assign value = raw_s1 - offset;

endmodule

// ===== sv/ioc_ctrl.sv =====
`timescale 1ns / 1ps

module ioc_ctrl
  import ioc_pkg::*;
#(
  parameter int SAMPLE_COUNT = IOC_SAMPLE_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_fire,
  input  logic         request_gyro_cal,
  input  logic         request_acc_cal,
  output ioc_sum_cmd_t gyro_sum_cmd,
  output ioc_sum_cmd_t acc_sum_cmd,
  output ioc_ofs_cmd_t gyro_ofs_cmd,
  output ioc_ofs_cmd_t acc_ofs_cmd,
  output ioc_flags_t   flags
);

  localparam ioc_count_t LAST = IOC_COUNT_W'(SAMPLE_COUNT);

  ioc_count_t   gyro_count, gyro_count_next;
  ioc_count_t   acc_count, acc_count_next;
  logic         gyro_done, gyro_done_next;
  logic         acc_done, acc_done_next;
  ioc_ofs_cmd_t gyro_ofs, gyro_ofs_next;
  ioc_ofs_cmd_t acc_ofs, acc_ofs_next;
  ioc_flags_t   flags_s1, flags_next;
  logic         stop;

  always_comb begin
    gyro_count_next = gyro_count;
    acc_count_next  = acc_count;
    gyro_done_next  = gyro_done;
    acc_done_next   = acc_done;
    gyro_sum_cmd    = '0;
    acc_sum_cmd     = '0;
    gyro_ofs_next   = '0;
    acc_ofs_next    = '0;
    stop            = 1'b0;
    if (in_fire) begin
      gyro_done_next = gyro_done & ~request_gyro_cal;
      acc_done_next  = acc_done & ~request_acc_cal;
      if (!gyro_done_next) begin
        if (gyro_count == '0) begin
          gyro_sum_cmd.sum_clr  = 1'b1;
          gyro_ofs_next.ofs_clr = 1'b1;
          gyro_count_next       = IOC_COUNT_W'(1);
          stop                  = 1'b1;
        end else begin
          gyro_sum_cmd.sum_add = 1'b1;
          if (gyro_count == LAST) begin
            gyro_ofs_next.ofs_load = 1'b1;
            gyro_count_next        = '0;
            gyro_done_next         = 1'b1;
            stop                   = 1'b1;
          end else begin
            gyro_count_next = gyro_count + IOC_COUNT_W'(1);
          end
        end
      end
      if (!stop && !acc_done_next) begin
        if (acc_count == '0) begin
          acc_sum_cmd.sum_clr  = 1'b1;
          acc_ofs_next.ofs_clr = 1'b1;
          acc_count_next       = IOC_COUNT_W'(1);
        end else begin
          acc_sum_cmd.sum_add = 1'b1;
          if (acc_count == LAST) begin
            acc_ofs_next.ofs_load = 1'b1;
            acc_count_next        = '0;
            acc_done_next         = 1'b1;
          end else begin
            acc_count_next = acc_count + IOC_COUNT_W'(1);
          end
        end
      end
    end
  end

  always_comb begin
    flags_next.gyro_cal_done     = gyro_done_next;
    flags_next.acc_cal_done      = acc_done_next;
    flags_next.gyro_offset_ready = gyro_ofs_next.ofs_load;
    flags_next.acc_offset_ready  = acc_ofs_next.ofs_load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_count <= '0;
      acc_count  <= '0;
      gyro_done  <= 1'b0;
      acc_done   <= 1'b0;
      gyro_ofs   <= '0;
      acc_ofs    <= '0;
    end else begin
      gyro_count <= gyro_count_next;
      acc_count  <= acc_count_next;
      gyro_done  <= gyro_done_next;
      acc_done   <= acc_done_next;
      if (in_fire) begin
        gyro_ofs <= gyro_ofs_next;
        acc_ofs  <= acc_ofs_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      flags_s1 <= flags_next;
    end
  end

  assign gyro_ofs_cmd = gyro_ofs;
  assign acc_ofs_cmd  = acc_ofs;
  assign flags        = flags_s1;

endmodule

// ===== sv/imu_offset_calibrator_unit.sv =====
`timescale 1ns / 1ps
// six-axis offset removal with averaging calibration
// sample channel (sink): one beat carries three accel and three gyro raw words
//   and the two calibration request bits
// result channel (source): one beat per sample beat, in order, with each axis
//   minus its offset, the two done flags and the two offset-ready pulses
// a sample beat can be taken every cycle unless both stages are full; its result beat
//   is offered from the output register (control and sums update on accept, the lane
//   subtract and offset update on the second stage, then the output register)
// the offset of each axis is written when its stage-two beat moves on, so the
//   next beat already sees it; a finish step divides the sum by the sample count
//   through a reciprocal multiply in the lane
// reset clears offsets, sums, counters and done flags; the first sample after
//   reset starts a gyro calibration
// when the receiver stalls the output register holds, stage two fills, and the
//   sample channel drops ready only once both stages are full
module imu_offset_calibrator_unit
  import ioc_pkg::*;
#(
  parameter int SAMPLE_COUNT = IOC_SAMPLE_COUNT
) (
  input  logic          clk,
  input  logic          rst,
  ioc_sample_if.sink    sample,
  ioc_result_if.source  result
);

  logic         in_fire;
  logic         s1_valid;
  logic         s1_adv;
  logic         s1_fire;
  logic         s2_valid;
  ioc_sum_cmd_t gyro_sum_cmd, acc_sum_cmd;
  ioc_ofs_cmd_t gyro_ofs_cmd, acc_ofs_cmd;
  ioc_flags_t   flags;
  ioc_flags_t   flags_s2;
  ioc_word_t    raw   [IOC_LANES];
  ioc_word_t    value [IOC_LANES];
  ioc_word_t    res   [IOC_LANES];
  ioc_sum_cmd_t lane_sum_cmd [IOC_LANES];
  ioc_ofs_cmd_t lane_ofs_cmd [IOC_LANES];

  assign s1_adv       = !s2_valid || result.ready;
  assign s1_fire      = s1_valid && s1_adv;
  assign sample.ready = !s1_valid || s1_adv;
  assign in_fire      = sample.valid && sample.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        s2_valid <= 1'b1;
      end else if (result.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  ioc_ctrl #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_fire          (in_fire),
    .request_gyro_cal (sample.request_gyro_cal),
    .request_acc_cal  (sample.request_acc_cal),
    .gyro_sum_cmd     (gyro_sum_cmd),
    .acc_sum_cmd      (acc_sum_cmd),
    .gyro_ofs_cmd     (gyro_ofs_cmd),
    .acc_ofs_cmd      (acc_ofs_cmd),
    .flags            (flags)
  );

  assign raw[0] = sample.acc_x_raw;
  assign raw[1] = sample.acc_y_raw;
  assign raw[2] = sample.acc_z_raw;
  assign raw[3] = sample.gyro_x_raw;
  assign raw[4] = sample.gyro_y_raw;
  assign raw[5] = sample.gyro_z_raw;

  // accel z is never summed, so its offset stays zero
  always_comb begin
    for (int i = 0; i < IOC_LANES; i++) begin
      if (i >= IOC_LANE_GYRO_X) begin
        lane_sum_cmd[i] = gyro_sum_cmd;
        lane_ofs_cmd[i] = gyro_ofs_cmd;
      end else begin
        lane_sum_cmd[i] = acc_sum_cmd;
        lane_ofs_cmd[i] = acc_ofs_cmd;
      end
      if (i == IOC_LANE_ACC_Z) begin
        lane_sum_cmd[i].sum_add = 1'b0;
      end
    end
  end

  for (genvar g = 0; g < IOC_LANES; g++) begin : g_lane
    ioc_lane #(
      .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .in_fire (in_fire),
      .raw     (raw[g]),
      .sum_cmd (lane_sum_cmd[g]),
      .s1_fire (s1_fire),
      .ofs_cmd (lane_ofs_cmd[g]),
      .value   (value[g])
    );
  end

  // output register merges the lanes with the control flags
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res      <= value;
      flags_s2 <= flags;
    end
  end

  assign result.valid             = s2_valid;
  assign result.acc_x             = res[0];
  assign result.acc_y             = res[1];
  assign result.acc_z             = res[2];
  assign result.gyro_x            = res[3];
  assign result.gyro_y            = res[4];
  assign result.gyro_z            = res[5];
  assign result.gyro_cal_done     = flags_s2.gyro_cal_done;
  assign result.acc_cal_done      = flags_s2.acc_cal_done;
  assign result.gyro_offset_ready = flags_s2.gyro_offset_ready;
  assign result.acc_offset_ready  = flags_s2.acc_offset_ready;

endmodule

// ===== test/imu_offset_calibrator_unit_tb.sv =====
`timescale 1ns / 1ps

module imu_offset_calibrator_unit_tb;
  import ioc_pkg::*;

  typedef struct {
    ioc_word_t acc [3];
    ioc_word_t gyro [3];
    bit        req_gyro;
    bit        req_acc;
  } imu_sample_t;

  typedef struct {
    ioc_word_t acc [3];
    ioc_word_t gyro [3];
    bit        gyro_done;
    bit        acc_done;
    bit        gyro_pulse;
    bit        acc_pulse;
  } imu_result_t;

  class ioc_scoreboard;
    ioc_word_t   gyro_ofs [3];
    ioc_word_t   acc_ofs [3];
    int          gyro_sum [3];
    int          acc_sum [3];
    int          gyro_cnt;
    int          acc_cnt;
    bit          gyro_done;
    bit          acc_done;
    imu_result_t due_q [$];
    int          mismatches;
    int          checked;
    int          gyro_cals;
    int          acc_cals;
    int          restarts;

    function new();
      for (int i = 0; i < 3; i++) begin
        gyro_ofs[i] = '0;
        acc_ofs[i]  = '0;
        gyro_sum[i] = 0;
        acc_sum[i]  = 0;
      end
      gyro_cnt   = 0;
      acc_cnt    = 0;
      gyro_done  = 0;
      acc_done   = 0;
      mismatches = 0;
      checked    = 0;
      gyro_cals  = 0;
      acc_cals   = 0;
      restarts   = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // predicts the result beat of one accepted sample and advances the calibration state
    function void note_sample(imu_sample_t s);
      imu_result_t r;
      bit halt;
      halt = 0;
      if (s.req_gyro && gyro_done) restarts++;
      if (s.req_acc && acc_done) restarts++;
      if (s.req_gyro) gyro_done = 0;
      if (s.req_acc) acc_done = 0;
      for (int i = 0; i < 3; i++) begin
        r.acc[i]  = s.acc[i] - acc_ofs[i];
        r.gyro[i] = s.gyro[i] - gyro_ofs[i];
      end
      r.gyro_pulse = 0;
      r.acc_pulse  = 0;

      if (!gyro_done) begin
        if (gyro_cnt == 0) begin
          for (int i = 0; i < 3; i++) begin
            gyro_ofs[i] = '0;
            gyro_sum[i] = 0;
          end
          gyro_cnt = 1;
          halt = 1;
        end else begin
          for (int i = 0; i < 3; i++) gyro_sum[i] += r.gyro[i];
          if (gyro_cnt == IOC_SAMPLE_COUNT) begin
            for (int i = 0; i < 3; i++) gyro_ofs[i] = ioc_word_t'(gyro_sum[i] / IOC_SAMPLE_COUNT);
            gyro_cnt = 0;
            gyro_done = 1;
            r.gyro_pulse = 1;
            gyro_cals++;
            halt = 1;
          end else begin
            gyro_cnt++;
          end
        end
      end

      if (!halt && !acc_done) begin
        if (acc_cnt == 0) begin
          for (int i = 0; i < 3; i++) begin
            acc_ofs[i] = '0;
            acc_sum[i] = 0;
          end
          acc_cnt = 1;
        end else begin
          // z axis is never summed
          acc_sum[0] += r.acc[0];
          acc_sum[1] += r.acc[1];
          if (acc_cnt == IOC_SAMPLE_COUNT) begin
            for (int i = 0; i < 3; i++) acc_ofs[i] = ioc_word_t'(acc_sum[i] / IOC_SAMPLE_COUNT);
            acc_cnt = 0;
            acc_done = 1;
            r.acc_pulse = 1;
            acc_cals++;
          end else begin
            acc_cnt++;
          end
        end
      end

      r.gyro_done = gyro_done;
      r.acc_done  = acc_done;
      due_q.push_back(r);
    endfunction

    function void check_result(imu_result_t got);
      imu_result_t want;
      bit bad;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing outstanding", $time);
        return;
      end
      want = due_q.pop_front();
      checked++;
      bad = (got.gyro_done != want.gyro_done) || (got.acc_done != want.acc_done) ||
            (got.gyro_pulse != want.gyro_pulse) || (got.acc_pulse != want.acc_pulse);
      for (int i = 0; i < 3; i++)
        if (got.acc[i] !== want.acc[i] || got.gyro[i] !== want.gyro[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result beat %0d mismatch", $time, checked);
          $display("  got  acc %0d %0d %0d gyro %0d %0d %0d done g%b a%b ready g%b a%b",
                   got.acc[0], got.acc[1], got.acc[2], got.gyro[0], got.gyro[1],
                   got.gyro[2], got.gyro_done, got.acc_done, got.gyro_pulse, got.acc_pulse);
          $display("  want acc %0d %0d %0d gyro %0d %0d %0d done g%b a%b ready g%b a%b",
                   want.acc[0], want.acc[1], want.acc[2], want.gyro[0], want.gyro[1],
                   want.gyro[2], want.gyro_done, want.acc_done, want.gyro_pulse,
                   want.acc_pulse);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  ioc_sample_if sample_ch ();
  ioc_result_if result_ch ();

  imu_offset_calibrator_unit #(
    .SAMPLE_COUNT(IOC_SAMPLE_COUNT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  ioc_scoreboard sb;
  int acc_bias [3];
  int gyro_bias [3];
  int spread;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int draw_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic ioc_word_t jitter_word(int bias, int width);
    if ($urandom_range(0, 15) == 0) return ioc_word_t'($urandom_range(0, 65535));
    return ioc_word_t'(bias + int'($urandom_range(0, 2 * width)) - width);
  endfunction

  task automatic pick_bias();
    bit pinned;
    pinned = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 3))
      0: spread = 3;
      1: spread = 100;
      2: spread = 2000;
      default: spread = 32767;
    endcase
    if (pinned) spread = 0;
    for (int i = 0; i < 3; i++) begin
      if (pinned) begin
        acc_bias[i]  = $urandom_range(0, 1) ? 32767 : -32768;
        gyro_bias[i] = $urandom_range(0, 1) ? 32767 : -32768;
      end else begin
        acc_bias[i]  = int'($urandom_range(0, 65535)) - 32768;
        gyro_bias[i] = int'($urandom_range(0, 65535)) - 32768;
      end
    end
  endtask

  // valid stays high after a beat when the next one follows at once
  task automatic send_sample(input imu_sample_t s, input int gap);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid            <= 1'b1;
    sample_ch.acc_x_raw        <= s.acc[0];
    sample_ch.acc_y_raw        <= s.acc[1];
    sample_ch.acc_z_raw        <= s.acc[2];
    sample_ch.gyro_x_raw       <= s.gyro[0];
    sample_ch.gyro_y_raw       <= s.gyro[1];
    sample_ch.gyro_z_raw       <= s.gyro[2];
    sample_ch.request_gyro_cal <= s.req_gyro;
    sample_ch.request_acc_cal  <= s.req_acc;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side with random stalls
  initial begin
    int stall;
    bit calm;
    int beats;
    imu_result_t got;
    beats = 0;
    calm = 0;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (beats % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      stall = draw_gap(calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      got.acc[0]     = result_ch.acc_x;
      got.acc[1]     = result_ch.acc_y;
      got.acc[2]     = result_ch.acc_z;
      got.gyro[0]    = result_ch.gyro_x;
      got.gyro[1]    = result_ch.gyro_y;
      got.gyro[2]    = result_ch.gyro_z;
      got.gyro_done  = result_ch.gyro_cal_done;
      got.acc_done   = result_ch.acc_cal_done;
      got.gyro_pulse = result_ch.gyro_offset_ready;
      got.acc_pulse  = result_ch.acc_offset_ready;
      sb.check_result(got);
      beats++;
    end
  end

  initial begin
    int pat [7];
    imu_sample_t s;
    bit calm;
    bit fresh;
    sb = new();
    pat = '{-32768, 32767, 0, -1, 21845, -21846, 1};
    rst <= 1'b1;
    sample_ch.valid            <= 1'b0;
    sample_ch.acc_x_raw        <= '0;
    sample_ch.acc_y_raw        <= '0;
    sample_ch.acc_z_raw        <= '0;
    sample_ch.gyro_x_raw       <= '0;
    sample_ch.gyro_y_raw       <= '0;
    sample_ch.gyro_z_raw       <= '0;
    sample_ch.request_gyro_cal <= 1'b0;
    sample_ch.request_acc_cal  <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme words, requests while both calibrations are still pending
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < 3; i++) begin
        s.acc[i]  = ioc_word_t'(pat[(k + i) % 7]);
        s.gyro[i] = ioc_word_t'(pat[(k + 3 + i) % 7]);
      end
      s.req_gyro = k[1];
      s.req_acc  = k[2];
      send_sample(s, draw_gap(k < 8));
    end

    pick_bias();
    calm = 0;
    for (int k = 0; k < 1500; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (k == 700 || $urandom_range(0, 299) == 0) drain_results();
      s.req_gyro = sb.gyro_done ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 99) == 0);
      s.req_acc  = sb.acc_done ? ($urandom_range(0, 39) == 0) : ($urandom_range(0, 99) == 0);
      fresh = (s.req_gyro && sb.gyro_done) || (s.req_acc && sb.acc_done);
      if (fresh) pick_bias();
      for (int i = 0; i < 3; i++) begin
        s.acc[i]  = jitter_word(acc_bias[i], spread);
        s.gyro[i] = jitter_word(gyro_bias[i], spread);
      end
      send_sample(s, draw_gap(calm));
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("%0d result beats checked, %0d gyro and %0d accel calibrations finished",
             sb.checked, sb.gyro_cals, sb.acc_cals);
    $display("%0d calibrations restarted on request, %0d mismatching beats",
             sb.restarts, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
